// File: design/min_tracking_stack_top_defines.svh
// ---------------------------------------------------------------------------
// Min-tracking stack assertion macros
// Shared property macros for the stack datapath checks.
// ---------------------------------------------------------------------------
`ifndef MIN_TRACKING_STACK_TOP_DEFINES_SVH
`define MIN_TRACKING_STACK_TOP_DEFINES_SVH

// Checks that cons holds in the same cycle as ante.
`define MTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that cons holds in the cycle after ante.
`define MTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/mts_pkg.sv
// ---------------------------------------------------------------------------
// Min-tracking stack package
// Codes, controller states and control structs shared by the stack modules.
// ---------------------------------------------------------------------------
package mts_pkg;

    // Widths of the stream payloads, fixed by the item format.
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 80;
    localparam int FIELD_W    = 32;
    localparam int FILL_W     = 9;

    typedef enum logic
    {
        FUNC_PUSH = 1'b0,
        FUNC_POP  = 1'b1
    } func_t;

    typedef enum logic [1:0]
    {
        STATUS_OK        = 2'd0,
        STATUS_POP_EMPTY = 2'd1,
        STATUS_PUSH_FULL = 2'd2
    } status_t;

    typedef enum logic
    {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed
    {
        logic capture;   // Latch the request and read the top entries.
        logic execute;   // Apply the operation and load the result register.
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed
    {
        logic out_stall; // Result register holds a result not yet taken.
    } dp_status_t;

endpackage

// File: design/mts_ctrl.sv
// ---------------------------------------------------------------------------
// Min-tracking stack controller
// Two-state sequencer that accepts a request and then executes it.
// ---------------------------------------------------------------------------
module mts_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  mts_pkg::dp_status_t stat,
    output mts_pkg::cmd_t       cmd
);

    mts_pkg::state_t state_reg;
    mts_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mts_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        unique case (state_reg)
            mts_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = mts_pkg::ST_EXEC;
                end
            end
            mts_pkg::ST_EXEC:
            begin
                // Wait here while the previous result is still unclaimed.
                if (!stat.out_stall)
                begin
                    cmd.execute = 1'b1;
                    state_next  = mts_pkg::ST_IDLE;
                end
            end
        endcase
    end

endmodule

// File: design/mts_dp.sv
// ---------------------------------------------------------------------------
// Min-tracking stack datapath
// Value and minimum memories, fill count, cached top minimum, result register.
// ---------------------------------------------------------------------------
`include "min_tracking_stack_top_defines.svh"

module mts_dp
#(
    parameter int STACK_DEPTH = 256,
    parameter int WORD_WIDTH  = 32
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [mts_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic [0:0]                        s_tuser,
    input  mts_pkg::cmd_t                     cmd,
    output mts_pkg::dp_status_t               stat,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mts_pkg::OUT_DATA_W-1:0]    m_tdata
);

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

    logic [WORD_WIDTH-1:0] value_mem [STACK_DEPTH];
    logic [WORD_WIDTH-1:0] min_mem   [STACK_DEPTH];

    mts_pkg::func_t               func_reg;
    logic [WORD_WIDTH-1:0]        word_reg;
    logic [WORD_WIDTH-1:0]        rd_val_reg;
    logic [WORD_WIDTH-1:0]        rd_min_reg;
    logic [WORD_WIDTH-1:0]        top_min_reg;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic                         out_valid_reg;
    logic [mts_pkg::OUT_DATA_W-1:0] out_data_reg;

    logic [WORD_WIDTH+31:0]       push_ext;
    logic [ADDR_W-1:0]            wr_addr;
    logic [ADDR_W-1:0]            rd_val_addr;
    logic [ADDR_W-1:0]            rd_min_addr;
    logic                         stack_empty;
    logic                         stack_full;
    logic                         push_less;
    logic                         write_en;
    mts_pkg::status_t             status_res;
    logic [WORD_WIDTH-1:0]        popped_res;
    logic [WORD_WIDTH-1:0]        new_min;
    logic [WORD_WIDTH-1:0]        min_res;
    logic [WORD_WIDTH+31:0]       popped_ext;
    logic [WORD_WIDTH+31:0]       min_ext;
    logic [CNT_W+8:0]             fill_ext;
    logic                         empty_res;

    // Sign-extend the 32-bit request word, then hold it at the stack width.
    assign push_ext = {{WORD_WIDTH{s_tdata[mts_pkg::IN_DATA_W-1]}}, s_tdata};

    assign wr_addr     = count_reg[ADDR_W-1:0];
    assign rd_val_addr = count_reg[ADDR_W-1:0] - ADDR_W'(1);
    assign rd_min_addr = count_reg[ADDR_W-1:0] - ADDR_W'(2);

    assign stack_empty = (count_reg == '0);
    assign stack_full  = (count_reg == CNT_W'(STACK_DEPTH));
    assign push_less   = ($signed(word_reg) < $signed(top_min_reg));

    always_comb
    begin
        count_next = count_reg;
        status_res = mts_pkg::STATUS_OK;
        popped_res = '0;
        new_min    = top_min_reg;
        write_en   = 1'b0;
        unique case (func_reg)
            mts_pkg::FUNC_PUSH:
            begin
                if (stack_full)
                begin
                    status_res = mts_pkg::STATUS_PUSH_FULL;
                end
                else
                begin
                    write_en   = 1'b1;
                    new_min    = (!stack_empty && !push_less) ? top_min_reg : word_reg;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            mts_pkg::FUNC_POP:
            begin
                if (stack_empty)
                begin
                    status_res = mts_pkg::STATUS_POP_EMPTY;
                end
                else
                begin
                    popped_res = rd_val_reg;
                    new_min    = rd_min_reg;
                    count_next = count_reg - CNT_W'(1);
                end
            end
        endcase
    end

    assign empty_res  = (count_next == '0);
    assign min_res    = empty_res ? '0 : new_min;
    assign popped_ext = {32'b0, popped_res};
    assign min_ext    = {32'b0, min_res};
    assign fill_ext   = {9'b0, count_next};

    // Memories: read top value and min below it on capture, write new top on push.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rd_val_reg <= value_mem[rd_val_addr];
            rd_min_reg <= min_mem[rd_min_addr];
        end
        if (cmd.execute && write_en)
        begin
            value_mem[wr_addr] <= word_reg;
            min_mem[wr_addr]   <= new_min;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= mts_pkg::func_t'(s_tuser[0]);
            word_reg <= push_ext[WORD_WIDTH-1:0];
        end
        if (cmd.execute)
        begin
            top_min_reg  <= new_min;
            out_data_reg <= {4'b0, status_res, empty_res,
                             fill_ext[mts_pkg::FILL_W-1:0],
                             min_ext[mts_pkg::FIELD_W-1:0],
                             popped_ext[mts_pkg::FIELD_W-1:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.execute)
            begin
                count_reg <= count_next;
            end
            if (cmd.execute)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.out_stall = out_valid_reg && !m_tready;
    assign m_tvalid       = out_valid_reg;
    assign m_tdata        = out_data_reg;

    `MTS_ASSERT_NOW(a_count_in_range, 1'b1, count_reg <= CNT_W'(STACK_DEPTH),
        "fill count beyond stack depth")
    `MTS_ASSERT_NOW(a_no_overwrite, cmd.execute, !(out_valid_reg && !m_tready),
        "result register loaded while an unclaimed result waits")
    `MTS_ASSERT_NOW(a_cmd_exclusive, 1'b1, !(cmd.capture && cmd.execute),
        "capture and execute in the same cycle")
    `MTS_ASSERT_NEXT(a_count_only_on_exec, !cmd.execute, $stable(count_reg),
        "fill count changed without an executed request")
    `MTS_ASSERT_NEXT(a_reject_keeps_count, cmd.execute && (status_res != mts_pkg::STATUS_OK),
        $stable(count_reg), "rejected request changed the fill count")

endmodule

// File: design/min_tracking_stack_top.sv
// ---------------------------------------------------------------------------
// Min-tracking stack
// Bounded LIFO of signed words that reports the running minimum per request.
// ---------------------------------------------------------------------------
//
// Channel   Dir   Handshake           Payload
// s_*       in    s_tvalid/s_tready   tdata push_value, tuser func
// m_*       out   m_tvalid/m_tready   tdata popped_value, current_minimum,
//                                     fill_count, is_empty, status
//
// A request has a capture step, which reads the top entries of the value and
// minimum memories (registered read port), then an execute step to apply it.
// A new request is accepted while the previous result still waits on m_*; the
// execute cycle then holds until that result has been taken.
// Reset (rst_n low, asynchronous) empties the stack; memory contents are not
// cleared, as only entries below the fill count are ever used.
//
// Every request produces exactly one result. A push onto a full stack or a pop
// from an empty one changes nothing and is flagged in the status field.
// The minimum of each level is stored next to its value, so a pop restores the
// previous minimum from memory, and the top minimum is cached in a register so
// a push needs only a compare against it.
//
module min_tracking_stack_top
#(
    parameter int STACK_DEPTH = 256,
    parameter int WORD_WIDTH  = 32
)
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [31:0] push_value (signed)
    input  logic [mts_pkg::IN_DATA_W-1:0]   s_tdata,
    // [0] func: 0 push, 1 pop
    input  logic [0:0]                      s_tuser,

    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [31:0] popped_value, [63:32] current_minimum, [72:64] fill_count,
    // [73] is_empty, [75:74] status, [79:76] zero
    output logic [mts_pkg::OUT_DATA_W-1:0]  m_tdata
);

    mts_pkg::cmd_t       cmd;
    mts_pkg::dp_status_t stat;

    // The controller sequences capture and execute; the datapath owns all state.
    mts_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mts_dp
    #(
        .STACK_DEPTH (STACK_DEPTH),
        .WORD_WIDTH  (WORD_WIDTH)
    )
    u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// File: dv/min_tracking_stack_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Min-tracking stack checker
// Watches both stream channels, predicts the report for each accepted request
// and compares it with the report the block returns.
// ---------------------------------------------------------------------------
module min_tracking_stack_checker
    import mts_pkg::*;
#(
    parameter int STACK_DEPTH = 256
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [IN_DATA_W-1:0]    s_tdata,
    input  logic [0:0]              s_tuser,
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [OUT_DATA_W-1:0]   m_tdata,
    output int                      mismatch_count,
    output int                      reports_due
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed
    {
        logic [FIELD_W-1:0] popped;
        logic [FIELD_W-1:0] minimum;
        logic [FILL_W-1:0]  fill;
        logic               empty;
        status_t            status;
    } stack_report_t;

    // Shadow copy of the stack: each level keeps its value and the minimum of
    // all levels at or below it.
    logic signed [FIELD_W-1:0] level_value   [STACK_DEPTH];
    logic signed [FIELD_W-1:0] level_minimum [STACK_DEPTH];
    int unsigned               levels_used = 0;

    stack_report_t report_queue[$];
    int            errors = 0;

    initial
    begin
        mismatch_count = 0;
        reports_due    = 0;
    end

    function automatic stack_report_t apply_stack_op(input func_t op,
                                                     input logic signed [FIELD_W-1:0] word);
        stack_report_t            rpt;
        logic signed [FIELD_W-1:0] run_min;
        rpt        = '0;
        rpt.status = STATUS_OK;
        if (op == FUNC_PUSH)
        begin
            if (levels_used >= STACK_DEPTH)
                rpt.status = STATUS_PUSH_FULL;
            else
            begin
                run_min = word;
                if (levels_used > 0 && !(word < level_minimum[levels_used-1]))
                    run_min = level_minimum[levels_used-1];
                level_value[levels_used]   = word;
                level_minimum[levels_used] = run_min;
                levels_used++;
            end
        end
        else
        begin
            if (levels_used == 0)
                rpt.status = STATUS_POP_EMPTY;
            else
            begin
                levels_used--;
                rpt.popped = level_value[levels_used];
            end
        end
        rpt.minimum = (levels_used > 0) ? level_minimum[levels_used-1] : '0;
        rpt.fill    = levels_used[FILL_W-1:0];
        rpt.empty   = (levels_used == 0);
        return rpt;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        stack_report_t seen;
        stack_report_t want;
        if (!rst_n)
        begin
            levels_used = 0;
            report_queue.delete();
            reports_due <= 0;
        end
        else
        begin
            // Results are compared before the request of this same edge is
            // predicted, since a request cannot return in the cycle it enters.
            if (m_tvalid && m_tready)
            begin
                seen.popped  = m_tdata[31:0];
                seen.minimum = m_tdata[63:32];
                seen.fill    = m_tdata[72:64];
                seen.empty   = m_tdata[73];
                seen.status  = status_t'(m_tdata[75:74]);
                if (report_queue.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("%0t: result with no request pending: data %h",
                                 $time, m_tdata);
                end
                else
                begin
                    want = report_queue.pop_front();
                    if (seen !== want)
                    begin
                        errors++;
                        if (errors <= REPORT_LIMIT)
                        begin
                            $display("%0t: result mismatch", $time);
                            $display("  expected popped %0d min %0d fill %0d empty %0b status %0d",
                                     $signed(want.popped), $signed(want.minimum), want.fill,
                                     want.empty, want.status);
                            $display("  actual   popped %0d min %0d fill %0d empty %0b status %0d",
                                     $signed(seen.popped), $signed(seen.minimum), seen.fill,
                                     seen.empty, seen.status);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                report_queue.push_back(apply_stack_op(func_t'(s_tuser[0]), s_tdata));
            reports_due <= report_queue.size();
        end
        mismatch_count <= errors;
    end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Min-tracking stack testbench
// Drives push and pop requests into the stack, with random idling on both
// channels, and leaves all checking to the checker instance beside the block.
// ---------------------------------------------------------------------------
module tb_top;
    import mts_pkg::*;

    localparam int DEPTH        = 256;
    localparam int RANDOM_COUNT = 1950;
    localparam int HOLD_CYCLES  = 300;   // long receiver stall in the last phase
    localparam int SETTLE       = 10;    // a request passes a capture and an execute step in the block
    localparam int LIMIT_NS     = 4_000_000;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata  = '0;
    logic [0:0]             s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;

    int mismatch_count;
    int reports_due;

    // Idle rates in percent, changed by the stimulus between phases.
    int send_idle_pct = 7;
    int recv_idle_pct = 88;
    int requests_sent = 0;

    // Set once by the stimulus; the receiver then makes its one long stall.
    bit hold_off_go   = 1'b0;
    bit hold_off_done = 1'b0;

    min_tracking_stack_top
    #(
        .STACK_DEPTH (DEPTH),
        .WORD_WIDTH  (32)
    )
    dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    min_tracking_stack_checker
    #(
        .STACK_DEPTH (DEPTH)
    )
    checker_i
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .reports_due    (reports_due)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // The run must end well before this even with every result waiting out
    // the heaviest stalls.
    initial
    begin
        #(LIMIT_NS);
        $display("FAIL min_tracking_stack_top");
        $finish;
    end

    // Receiver: random back-pressure, plus one long stall on request of the
    // stimulus so that the block fills up and stops taking requests.
    initial
    begin : receiver
        forever
        begin
            @(posedge clk);
            if (hold_off_go && !hold_off_done)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                hold_off_done = 1'b1;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Offers one request, with random idle cycles ahead of it, and returns at
    // the edge where it is accepted. tvalid stays high for the next request.
    task automatic send_request(input func_t op, input logic [31:0] word);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= word;
        do
            @(posedge clk);
        while (!s_tready);
        requests_sent++;
    endtask

    // Stops offering until the block has returned every pending result.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (reports_due != 0);
    endtask

    // Extremes, small values that collide with the running minimum, and
    // uniform random words.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3, 4: return $urandom_range(0, 15) - 8;
            default: return $urandom();
        endcase
    endfunction

    initial
    begin : stimulus
        int    phase;
        int    seg_len;
        int    push_pct;
        int    i;
        bit    first_segment;
        func_t op;

        phase         = 0;
        first_segment = 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: a pop on the empty stack, the word extremes, a push
        // equal to the current minimum, draining back to empty and popping
        // once more, then bit patterns that toggle every data bit.
        send_request(FUNC_POP,  32'hFFFF_FFFF);
        send_request(FUNC_PUSH, 32'h7FFF_FFFF);
        send_request(FUNC_PUSH, 32'h8000_0000);
        send_request(FUNC_PUSH, 32'd5);
        send_request(FUNC_PUSH, 32'h8000_0000);
        send_request(FUNC_POP,  32'h0);
        send_request(FUNC_POP,  32'h1234_5678);
        send_request(FUNC_POP,  32'h0);
        send_request(FUNC_POP,  32'h0);
        send_request(FUNC_POP,  32'hFFFF_FFFF);
        send_request(FUNC_PUSH, 32'hFFFF_FFFF);
        send_request(FUNC_PUSH, 32'h0);
        send_request(FUNC_PUSH, 32'hFFFF_FFFF);
        send_request(FUNC_PUSH, 32'hFFFF_FFFE);
        send_request(FUNC_PUSH, 32'h5555_5555);
        send_request(FUNC_PUSH, 32'hAAAA_AAAA);
        send_request(FUNC_POP,  32'h0);
        send_request(FUNC_POP,  32'h0);
        send_request(FUNC_POP,  32'h0);
        send_request(FUNC_POP,  32'h0);
        send_request(FUNC_POP,  32'h0);
        send_request(FUNC_POP,  32'h0);
        send_request(FUNC_POP,  32'h0);
        drain_results();
        requests_sent = 0;

        // Random part in segments that fill, drain or churn the stack. The
        // first segment is always push-heavy so that pushes onto a full stack occur.
        while (requests_sent < RANDOM_COUNT)
        begin
            if (first_segment)
            begin
                push_pct = 95;
                seg_len  = 300;
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:       push_pct = 95;
                    1:       push_pct = 5;
                    default: push_pct = 50;
                endcase
                seg_len = $urandom_range(30, 320);
            end
            first_segment = 1'b0;

            for (i = 0; i < seg_len && requests_sent < RANDOM_COUNT; i++)
            begin
                // Three idling phases over the random part; the sender waits
                // for the block to empty its pipeline at each change.
                if (requests_sent * 3 / RANDOM_COUNT != phase)
                begin
                    phase = requests_sent * 3 / RANDOM_COUNT;
                    drain_results();
                    if (phase == 1)
                    begin
                        send_idle_pct = 88;
                        recv_idle_pct = 7;
                    end
                    else
                    begin
                        send_idle_pct = 0;
                        recv_idle_pct = 0;
                        hold_off_go   = 1'b1;
                    end
                end
                op = ($urandom_range(0, 99) < push_pct) ? FUNC_PUSH : FUNC_POP;
                send_request(op, pick_word());
            end
        end

        drain_results();
        repeat (SETTLE) @(posedge clk);

        if (mismatch_count == 0 && reports_due == 0)
            $display("PASS min_tracking_stack_top");
        else
            $display("FAIL min_tracking_stack_top");
        $finish;
    end

endmodule
